[rtl/core/btc_pkg.sv]
// shared constants and helpers for the bit matrix transitive closure block
// no dependencies
package btc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int ROW_W        = 32;
    localparam int IDX_W        = 5;
    localparam int CNT_W        = 6;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_PAD_W    = OUT_TDATA_W - ROW_W - IDX_W;

    localparam logic [CNT_W-1:0] VC_RESET = CNT_W'(32);
    localparam logic [CNT_W-1:0] VC_MAX   = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_SAT  = '1;

    // vertex count saturated to 1 .. MAX_VERTICES
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] vc);
        logic [CNT_W-1:0] n;
        n = vc;
        if (vc == '0) begin
            n = CNT_W'(1);
        end else if (vc > VC_MAX) begin
            n = VC_MAX;
        end
        return n;
    endfunction

    // low n columns set
    function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W:0] one_hot;
        one_hot = (ROW_W+1)'(1) << n;
        return one_hot[ROW_W-1:0] - ROW_W'(1);
    endfunction

endpackage

[rtl/core/btc_ram.sv]
// generic ram, one write port and one read port with registered read data
// no dependencies
module btc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[rtl/core/bit_matrix_transitive_closure.sv]
// top level of the bit matrix transitive closure block: row store, closure sequencer, readout
// depends on btc_pkg and btc_ram
//
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | s_tdata row_bits, s_tlast last_row
//  m_      | out | m_tvalid / m_tready   | m_tdata row_index, closed_bits; m_tlast last
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_data vertex_count
//
// rows load one per cycle; the item with tlast starts closure and readout
// each closure pass reads, scans and rewrites each row via the single row store read port,
// passes repeat until a pass adds no bit, that last pass only confirms the result
// readout sends each row, holding through output stalls, then clears the row valid bits
// s_tready is low from the tlast item until the readout is done; reset is synchronous
module bit_matrix_transitive_closure
    import btc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] row_bits
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [4:0] row_index, [36:5] closed_bits
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CNT_W-1:0]       cfg_data
);

    typedef enum logic [3:0] {
        ST_LOAD, ST_RD_ROW, ST_LATCH, ST_SCAN, ST_WRITE,
        ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT, ST_CLEAR
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        vc_reg;
    logic [CNT_W-1:0]        loaded_reg;
    logic [MAX_VERTICES-1:0] valid_reg;
    logic                    rvld_reg;
    logic [IDX_W-1:0]        i_reg;
    logic [IDX_W-1:0]        t_reg;
    logic [ROW_W-1:0]        acc_reg;
    logic                    changed_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic                    m_tlast_reg;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] n_last;
    logic [ROW_W-1:0] mask;
    logic             s_acc;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] rrow;
    logic             i_is_last;
    logic             t_is_last;

    assign n_eff     = eff_count(vc_reg);
    assign n_last    = n_eff - CNT_W'(1);
    assign mask      = col_mask(n_eff);
    assign s_tready  = (state_reg == ST_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign rrow      = ram_rdata & {ROW_W{rvld_reg}} & mask;
    assign i_is_last = ({1'b0, i_reg} == n_last);
    assign t_is_last = ({1'b0, t_reg} == n_last);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = i_reg;
        ram_wdata = acc_reg;
        ram_raddr = i_reg;
        unique case (state_reg)
            ST_LOAD: begin
                ram_we    = s_acc && (loaded_reg < n_eff);
                ram_waddr = loaded_reg[IDX_W-1:0];
                ram_wdata = s_tdata[ROW_W-1:0] & mask;
            end
            ST_WRITE: begin
                ram_we = 1'b1;
            end
            ST_LATCH: begin
                ram_raddr = '0;
            end
            ST_SCAN: begin
                ram_raddr = t_reg + IDX_W'(1);
            end
            ST_RD_ROW, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT, ST_CLEAR: begin
                ram_raddr = i_reg;
            end
            default: begin
                ram_raddr = i_reg;
            end
        endcase
    end

    btc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            vc_reg       <= VC_RESET;
            loaded_reg   <= '0;
            valid_reg    <= '0;
            rvld_reg     <= 1'b0;
            i_reg        <= '0;
            t_reg        <= '0;
            changed_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            rvld_reg <= valid_reg[ram_raddr];
            if (cfg_valid && cfg_ready) begin
                vc_reg <= cfg_data;
            end
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (loaded_reg != CNT_SAT) begin
                            loaded_reg <= loaded_reg + CNT_W'(1);
                        end
                        if (s_tlast) begin
                            i_reg       <= '0;
                            changed_reg <= 1'b0;
                            state_reg   <= ST_RD_ROW;
                        end
                    end
                end
                ST_RD_ROW: begin
                    state_reg <= ST_LATCH;
                end
                ST_LATCH: begin
                    acc_reg   <= rrow;
                    t_reg     <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (t_reg != i_reg && acc_reg[t_reg]) begin
                        acc_reg <= acc_reg | rrow;
                        if ((rrow & ~acc_reg) != '0) begin
                            changed_reg <= 1'b1;
                        end
                    end
                    if (t_is_last) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        t_reg <= t_reg + IDX_W'(1);
                    end
                end
                ST_WRITE: begin
                    if (!i_is_last) begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= ST_RD_ROW;
                    end else if (changed_reg) begin
                        i_reg       <= '0;
                        changed_reg <= 1'b0;
                        state_reg   <= ST_RD_ROW;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= ST_OUT_RD;
                    end
                end
                ST_OUT_RD: begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= {{OUT_PAD_W{1'b0}}, rrow, i_reg};
                    m_tlast_reg  <= i_is_last;
                    state_reg    <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (i_is_last) begin
                            state_reg <= ST_CLEAR;
                        end else begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                ST_CLEAR: begin
                    valid_reg   <= '0;
                    loaded_reg  <= '0;
                    i_reg       <= '0;
                    changed_reg <= 1'b0;
                    state_reg   <= ST_LOAD;
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("intake open while a result item is pending");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ({1'b0, t_reg} < n_eff && {1'b0, i_reg} < n_eff))
        else $error("closure scan index beyond vertex count");

    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |=> (valid_reg == '0 && loaded_reg == '0))
        else $error("row store not cleared after readout");

    a_out_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[IDX_W-1:0]} < n_eff))
        else $error("result row index beyond vertex count");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == ST_CLEAR))
        else $error("final result item did not end the run");
`endif

endmodule

[verif/bit_matrix_transitive_closure_tb.sv]
// testbench for bit_matrix_transitive_closure: loads adjacency rows, checks each closed row
// against a built-in closure predictor, with directed and random graphs under random stalls
// depends on btc_pkg and the block's rtl
`timescale 1ns / 100ps

module bit_matrix_transitive_closure_tb
    import btc_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PHASE_ITEMS = 100;
    localparam int          DIR_ROWS = 25;
    localparam int          EXP_DEPTH = 64;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] bits;
        logic             lst;
    } closed_row_t;

    typedef struct packed {
        bit               set_vc;
        logic [CNT_W-1:0] vc;
        logic [ROW_W-1:0] bits;
        logic             lst;
        bit               typed;
        logic [ROW_W-1:0] typed_bits;
    } dir_item_t;

    typedef enum int {ROW_RANDOM, ROW_SPARSE, ROW_CHAIN_UP, ROW_CHAIN_DOWN, ROW_THIN} row_style_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [31:0] row_bits
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [4:0] row_index, [36:5] closed_bits
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data = '0;

    logic [ROW_W-1:0] graph_rows [MAX_VERTICES] = '{default: '0};
    int               rows_seen = 0;
    logic [CNT_W-1:0] vc_reg = VC_RESET;
    closed_row_t      exp_fifo [EXP_DEPTH];
    int               exp_wr = 0;
    int               exp_rd = 0;
    int               mismatches = 0;
    int               send_gap_pct = 0;
    int               stall_pct = 0;
    int unsigned      cycle_cnt = 0;

    dir_item_t dir_stim [DIR_ROWS] = '{
        '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{1'b1, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0001},
        '{1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{1'b1, 6'd4,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_000F},
        '{1'b0, 6'd0,  32'h0000_0002, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0004, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0008, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0001, 1'b1, 1'b1, 32'h0000_000F},
        '{1'b0, 6'd0,  32'h0000_0002, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0004, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0008, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0},
        '{1'b1, 6'd3,  32'h0000_0002, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0004, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_FFFF, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0005, 1'b1, 1'b1, 32'h0000_0007},
        '{1'b0, 6'd0,  32'h0000_0006, 1'b1, 1'b0, 32'h0},
        '{1'b1, 6'd33, 32'h8000_0001, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0001, 1'b1, 1'b0, 32'h0},
        '{1'b1, 6'd2,  32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{1'b0, 6'd0,  32'h0000_0001, 1'b1, 1'b0, 32'h0}
    };

    bit_matrix_transitive_closure dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pending_count();
        return exp_wr - exp_rd;
    endfunction

    function automatic int live_count();
        if (vc_reg == '0) return 1;
        if (vc_reg > MAX_VERTICES) return MAX_VERTICES;
        return int'(vc_reg);
    endfunction

    function automatic logic [ROW_W-1:0] col_bits(input int n);
        return (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    endfunction

    function automatic void close_graph(input int n);
        logic [ROW_W-1:0] msk;
        logic [ROW_W-1:0] other;
        bit               changed;
        msk = col_bits(n);
        for (int i = 0; i < n; i++) graph_rows[i] &= msk;
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int i = 0; i < n; i++) begin
                for (int t = 0; t < n; t++) begin
                    if (t != i && graph_rows[i][t]) begin
                        other = graph_rows[t];
                        if (other != '0 && (other & ~graph_rows[i]) != '0) begin
                            graph_rows[i] |= other;
                            changed = 1'b1;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic void load_graph_row(input logic [ROW_W-1:0] bits, input logic lst,
                                           input bit typed, input logic [ROW_W-1:0] typed_bits);
        int          n;
        closed_row_t r;
        n = live_count();
        if (rows_seen < n) graph_rows[rows_seen] = bits & col_bits(n);
        if (rows_seen < 63) rows_seen++;
        if (lst) begin
            close_graph(n);
            for (int i = 0; i < n; i++) begin
                r.idx  = IDX_W'(i);
                r.bits = typed ? typed_bits : graph_rows[i];
                r.lst  = (i == n - 1);
                exp_fifo[exp_wr % EXP_DEPTH] = r;
                exp_wr++;
            end
            for (int i = 0; i < MAX_VERTICES; i++) graph_rows[i] = '0;
            rows_seen = 0;
        end
    endfunction

    function automatic logic [ROW_W-1:0] make_row(input row_style_t style, input int i,
                                                  input int n);
        logic [ROW_W-1:0] r;
        case (style)
            ROW_RANDOM: r = $urandom();
            ROW_SPARSE: begin
                r = ROW_W'(1) << $urandom_range(0, n - 1);
                if ($urandom_range(0, 2) == 0) r |= ROW_W'(1) << $urandom_range(0, n - 1);
            end
            ROW_CHAIN_UP: r = ROW_W'(1) << ((i + 1) % n);
            ROW_CHAIN_DOWN: r = ROW_W'(1) << ((i + n - 1) % n);
            default: r = $urandom() & $urandom() & $urandom();
        endcase
        if ($urandom_range(0, 15) == 0) r = $urandom_range(0, 1) ? '0 : '1;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int k;
        k = $urandom_range(0, 19);
        if (k < 12) return CNT_W'($urandom_range(1, 6));
        if (k < 15) return CNT_W'($urandom_range(7, 12));
        if (k == 15) return '0;
        if (k == 16) return CNT_W'(32);
        if (k == 17) return CNT_W'($urandom_range(33, 63));
        if (k == 18) return CNT_W'($urandom_range(13, 31));
        return CNT_W'(2);
    endfunction

    task automatic send_row(input logic [ROW_W-1:0] bits, input logic lst,
                            input bit typed, input logic [ROW_W-1:0] typed_bits);
        while ($urandom_range(1, 100) <= send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        load_graph_row(bits, lst, typed, typed_bits);
    endtask

    task automatic set_vertex_count(input logic [CNT_W-1:0] v);
        s_tvalid <= 1'b0;
        while (pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        vc_reg = v;
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        closed_row_t exp_row;
        logic [IDX_W-1:0] got_idx;
        logic [ROW_W-1:0] got_bits;
        got_idx  = m_tdata[IDX_W-1:0];
        got_bits = m_tdata[IDX_W+ROW_W-1:IDX_W];
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_count() == 0) begin
                if (mismatches < 10)
                    $display("unexpected item: idx %0d bits %h last %b",
                             got_idx, got_bits, m_tlast);
                mismatches++;
            end else begin
                exp_row = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got_idx !== exp_row.idx || got_bits !== exp_row.bits
                        || m_tlast !== exp_row.lst) begin
                    if (mismatches < 10)
                        $display("mismatch: expected %0d %h %b, got %0d %h %b",
                                 exp_row.idx, exp_row.bits, exp_row.lst,
                                 got_idx, got_bits, m_tlast);
                    mismatches++;
                end
            end
        end
        m_tready <= ($urandom_range(1, 100) > stall_pct);
    end

    initial begin
        int         gap_plan [4];
        int         stall_plan [4];
        int         phase_items;
        int         n;
        int         frame_len;
        int         k;
        bit         long_done;
        row_style_t style;
        gap_plan   = '{0, 45, 0, 26};
        stall_plan = '{0, 0, 45, 26};
        long_done  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int d = 0; d < DIR_ROWS; d++) begin
            if (dir_stim[d].set_vc) set_vertex_count(dir_stim[d].vc);
            send_row(dir_stim[d].bits, dir_stim[d].lst, dir_stim[d].typed, dir_stim[d].typed_bits);
        end

        for (int p = 0; p < 4; p++) begin
            send_gap_pct = gap_plan[p];
            stall_pct    = stall_plan[p];
            phase_items  = 0;
            set_vertex_count(pick_count());
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 2) == 0) set_vertex_count(pick_count());
                n     = live_count();
                style = row_style_t'($urandom_range(0, 4));
                k     = $urandom_range(0, 9);
                if (p == 1 && !long_done) begin
                    // overruns the saturating row counter
                    frame_len = $urandom_range(64, 70);
                    long_done = 1'b1;
                end else if (k < 7) begin
                    frame_len = n;
                end else if (k == 7) begin
                    frame_len = $urandom_range(1, n);
                end else begin
                    frame_len = n + $urandom_range(1, 4);
                end
                for (int r = 0; r < frame_len; r++)
                    send_row(make_row(style, r, n), r == frame_len - 1, 1'b0, '0);
                phase_items += frame_len;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_count() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_count() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/btc_pkg.sv
rtl/core/btc_ram.sv
rtl/core/bit_matrix_transitive_closure.sv
verif/bit_matrix_transitive_closure_tb.sv
